// ===== rtl/les_pkg.sv =====
// shared types, codes and constant tables of the led effect sequencer
package les_pkg;

   // event codes carried in the func field
   localparam logic [1:0] FUNC_START = 2'd0;
   localparam logic [1:0] FUNC_POLL  = 2'd1;
   localparam logic [1:0] FUNC_STOP  = 2'd2;

   // configuration register indexes
   localparam logic [1:0] CSR_EFFECT_MODE    = 2'd0;
   localparam logic [1:0] CSR_UPDATE_STEP_MS = 2'd1;
   localparam logic [1:0] CSR_GLOW_LEVEL     = 2'd2;

   localparam int CsrDataWidth = 16;

   localparam logic [15:0] STEP_RESET       = 16'd500;
   localparam logic [7:0]  BRIGHTNESS_RESET = 8'd160;

   // show timing in ms
   localparam logic [14:0] HEART_MS  = 15'd4000;
   localparam logic [14:0] WHEEL_END = 15'd10000;
   localparam logic [31:0] SHOW_MS   = 32'd18000;
   localparam logic [12:0] AUR_SPAN  = 13'd2000;

   // reciprocals: x/60 for x below 4000, and t*64/125 for t below 6000
   localparam logic [14:0] BEAT_RECIP  = 15'd17477;
   localparam logic [17:0] WHEEL_RECIP = 18'd134218;

   // wheel channel kinds
   localparam logic [1:0] KIND_FULL    = 2'd0;
   localparam logic [1:0] KIND_RISING  = 2'd1;
   localparam logic [1:0] KIND_FALLING = 2'd2;
   localparam logic [1:0] KIND_ZERO    = 2'd3;

   typedef struct packed {
      logic [1:0]  func;
      logic [31:0] now_ms;
      logic        fpga_ready;
      logic [7:0]  prior_red;
      logic [7:0]  prior_green;
      logic [7:0]  prior_blue;
      logic [7:0]  prior_brightness;
   } req_type;

   typedef struct packed {
      logic       led_write;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] brightness;
      logic       keep_going;
   } rsp_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] brightness;
   } led_type;

   typedef struct packed {
      logic        effect_mode;
      logic [15:0] update_step_ms;
      logic [7:0]  glow_level;
   } cfg_type;

   localparam logic [7:0] BEAT_TABLE [16] = '{
      8'd16, 8'd90, 8'd200, 8'd255, 8'd190, 8'd90, 8'd32, 8'd16,
      8'd24, 8'd120, 8'd170, 8'd120, 8'd48, 8'd16, 8'd16, 8'd16
   };

   localparam logic [7:0] BLINK_COLOUR [6][3] = '{
      '{8'd255, 8'd0, 8'd0}, '{8'd0, 8'd0, 8'd0}, '{8'd0, 8'd255, 8'd0},
      '{8'd0, 8'd0, 8'd0},   '{8'd0, 8'd0, 8'd255}, '{8'd0, 8'd0, 8'd0}
   };

   localparam logic [1:0] WHEEL_KIND [6][3] = '{
      '{KIND_FULL, KIND_RISING, KIND_ZERO},
      '{KIND_FALLING, KIND_FULL, KIND_ZERO},
      '{KIND_ZERO, KIND_FULL, KIND_RISING},
      '{KIND_ZERO, KIND_FALLING, KIND_FULL},
      '{KIND_RISING, KIND_ZERO, KIND_FULL},
      '{KIND_FULL, KIND_ZERO, KIND_FALLING}
   };

   // aurora segment start levels
   localparam logic [7:0] AUR_FROM [4][3] = '{
      '{8'd0, 8'd40, 8'd80}, '{8'd0, 8'd120, 8'd140},
      '{8'd40, 8'd0, 8'd190}, '{8'd0, 8'd190, 8'd110}
   };

   // ceil(|to - from| * 2^24 / 2000) per segment and channel
   localparam logic [20:0] AUR_COEF [4][3] = '{
      '{21'd0, 21'd671089, 21'd503317},
      '{21'd335545, 21'd1006633, 21'd419431},
      '{21'd335545, 21'd1593836, 21'd671089},
      '{21'd0, 21'd1258292, 21'd251659}
   };

   // set where the segment falls
   localparam logic AUR_NEG [4][3] = '{
      '{1'b0, 1'b0, 1'b0}, '{1'b0, 1'b1, 1'b0},
      '{1'b1, 1'b0, 1'b1}, '{1'b0, 1'b1, 1'b1}
   };

endpackage

// ===== rtl/led_effect_sequencer.sv =====
// LED effect sequencer: takes one start, poll or stop event per cycle unless stalled;
// each event is captured in an input register, decided by short logic against the
// effect state and the show frame generator, and its single result lands in an output
// register. The effect state is updated in the same cycle the result is registered, so
// back-to-back events see each other's effects and the sustained rate is one event per
// clock while rsp_stall is low. Configuration registers are read live at each poll.
module led_effect_sequencer (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  les_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output les_pkg::rsp_type                  rsp_data,
   input  logic                              csr_wr_en,
   input  logic [1:0]                        csr_index,
   input  logic [les_pkg::CsrDataWidth-1:0]  csr_wdata
);

   logic             in_vld_ff, in_vld_in;
   les_pkg::req_type in_data_ff;
   logic             rsp_vld_ff, rsp_vld_in;
   les_pkg::rsp_type rsp_data_ff;
   les_pkg::cfg_type cfg_ff;
   les_pkg::led_type frame;
   les_pkg::rsp_type result;
   logic [14:0]      elapsed;
   logic             advance;

   assign advance   = in_vld_ff & (~rsp_vld_ff | ~rsp_stall);
   assign req_stall = in_vld_ff & ~advance;
   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      in_vld_in = in_vld_ff;
      if (!req_stall) begin
         in_vld_in = req_valid;
      end
      rsp_vld_in = rsp_vld_ff;
      if (advance) begin
         rsp_vld_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         rsp_data_ff <= result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.effect_mode    <= 1'b0;
         cfg_ff.update_step_ms <= les_pkg::STEP_RESET;
         cfg_ff.glow_level     <= les_pkg::BRIGHTNESS_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            les_pkg::CSR_EFFECT_MODE:    cfg_ff.effect_mode    <= csr_wdata[0];
            les_pkg::CSR_UPDATE_STEP_MS: cfg_ff.update_step_ms <= csr_wdata;
            les_pkg::CSR_GLOW_LEVEL:     cfg_ff.glow_level     <= csr_wdata[7:0];
            default: begin
            end
         endcase
      end
   end

   les_event u_event (
      .clock   (clock),
      .reset   (reset),
      .fire    (advance),
      .item    (in_data_ff),
      .cfg     (cfg_ff),
      .frame   (frame),
      .elapsed (elapsed),
      .result  (result)
   );

   les_frame u_frame (
      .elapsed    (elapsed),
      .brightness (cfg_ff.glow_level),
      .frame      (frame)
   );

endmodule

// ===== rtl/les_frame.sv =====
// show frame generator: heartbeat, colour wheel and aurora blend from elapsed time
module les_frame (
   input  logic [14:0]      elapsed,
   input  logic [7:0]       brightness,
   output les_pkg::led_type frame
);

   logic [26:0] beat_prod;
   logic [3:0]  beat_idx;
   logic [12:0] wheel_t;
   logic [30:0] wheel_prod;
   logic [11:0] pos;
   logic [3:0]  sect_raw;
   logic [2:0]  sector;
   logic [7:0]  rising;
   logic [12:0] aur_t;
   logic [1:0]  seg;
   logic [10:0] into;
   logic [31:0] aur_prod [3];
   logic [7:0]  wheel_lvl [3];
   logic [7:0]  aur_lvl [3];

   always_comb begin
      beat_prod = {15'd0, elapsed[11:0]} * {12'd0, les_pkg::BEAT_RECIP};
      beat_idx  = beat_prod[23:20];

      wheel_t    = 13'(elapsed - les_pkg::HEART_MS);
      wheel_prod = {18'd0, wheel_t} * {13'd0, les_pkg::WHEEL_RECIP};
      pos        = wheel_prod[29:18];
      sect_raw   = pos[11:8];
      sector     = (sect_raw >= 4'd6) ? 3'(sect_raw - 4'd6) : sect_raw[2:0];
      rising     = pos[7:0];

      aur_t = 13'(elapsed - les_pkg::WHEEL_END);
      if (aur_t >= 13'd6000) begin
         seg  = 2'd3;
         into = 11'(aur_t - 13'd6000);
      end else if (aur_t >= 13'd4000) begin
         seg  = 2'd2;
         into = 11'(aur_t - 13'd4000);
      end else if (aur_t >= les_pkg::AUR_SPAN) begin
         seg  = 2'd1;
         into = 11'(aur_t - les_pkg::AUR_SPAN);
      end else begin
         seg  = 2'd0;
         into = aur_t[10:0];
      end

      for (int c = 0; c < 3; c++) begin
         case (les_pkg::WHEEL_KIND[sector][c])
            les_pkg::KIND_FULL:    wheel_lvl[c] = 8'd255;
            les_pkg::KIND_RISING:  wheel_lvl[c] = rising;
            les_pkg::KIND_FALLING: wheel_lvl[c] = ~rising;
            default:               wheel_lvl[c] = 8'd0;
         endcase
         // truncating signed interpolation: magnitude scaled, sign applied after
         aur_prod[c] = {21'd0, into} * {11'd0, les_pkg::AUR_COEF[seg][c]};
         aur_lvl[c]  = les_pkg::AUR_NEG[seg][c] ?
                       8'(les_pkg::AUR_FROM[seg][c] - aur_prod[c][31:24]) :
                       8'(les_pkg::AUR_FROM[seg][c] + aur_prod[c][31:24]);
      end

      if (elapsed < les_pkg::HEART_MS) begin
         frame.red        = 8'd255;
         frame.green      = 8'd24;
         frame.blue       = 8'd24;
         frame.brightness = les_pkg::BEAT_TABLE[beat_idx];
      end else if (elapsed < les_pkg::WHEEL_END) begin
         frame.red        = wheel_lvl[0];
         frame.green      = wheel_lvl[1];
         frame.blue       = wheel_lvl[2];
         frame.brightness = brightness;
      end else begin
         frame.red        = aur_lvl[0];
         frame.green      = aur_lvl[1];
         frame.blue       = aur_lvl[2];
         frame.brightness = brightness;
      end
   end

endmodule

// ===== rtl/les_event.sv =====
// effect state and per-event decision: start, poll and stop handling
module les_event (
   input  logic             clock,
   input  logic             reset,
   input  logic             fire,
   input  les_pkg::req_type item,
   input  les_pkg::cfg_type cfg,
   input  les_pkg::led_type frame,
   output logic [14:0]      elapsed,
   output les_pkg::rsp_type result
);

   logic [31:0]      start_time_ff, start_time_in;
   logic [31:0]      deadline_ff, deadline_in;
   logic [2:0]       phase_ff, phase_in;
   logic             led_ready_ff, led_ready_in;
   logic             saved_flag_ff, saved_flag_in;
   les_pkg::led_type saved_ff, saved_in;
   logic [31:0]      el;
   logic [31:0]      since_deadline;
   logic             due;

   assign el             = item.now_ms - start_time_ff;
   assign elapsed        = el[14:0];
   assign since_deadline = item.now_ms - deadline_ff;
   assign due            = ~since_deadline[31];

   always_comb begin
      start_time_in = start_time_ff;
      deadline_in   = deadline_ff;
      phase_in      = phase_ff;
      led_ready_in  = led_ready_ff;
      saved_flag_in = saved_flag_ff;
      saved_in      = saved_ff;
      result        = '0;
      case (item.func)
         les_pkg::FUNC_START: begin
            led_ready_in  = item.fpga_ready;
            start_time_in = item.now_ms;
            deadline_in   = item.now_ms;
            phase_in      = 3'd0;
            saved_flag_in = item.fpga_ready;
            if (item.fpga_ready) begin
               saved_in = '{red: item.prior_red, green: item.prior_green,
                            blue: item.prior_blue, brightness: item.prior_brightness};
            end
         end
         les_pkg::FUNC_STOP: begin
            if (saved_flag_ff) begin
               result.led_write  = 1'b1;
               result.red        = saved_ff.red;
               result.green      = saved_ff.green;
               result.blue       = saved_ff.blue;
               result.brightness = saved_ff.brightness;
               saved_flag_in     = 1'b0;
            end
         end
         les_pkg::FUNC_POLL: begin
            if (led_ready_ff) begin
               if (!cfg.effect_mode) begin
                  result.keep_going = 1'b1;
                  if (due) begin
                     deadline_in       = item.now_ms + {16'd0, cfg.update_step_ms};
                     result.led_write  = 1'b1;
                     result.red        = les_pkg::BLINK_COLOUR[phase_ff][0];
                     result.green      = les_pkg::BLINK_COLOUR[phase_ff][1];
                     result.blue       = les_pkg::BLINK_COLOUR[phase_ff][2];
                     result.brightness = cfg.glow_level;
                     phase_in          = (phase_ff == 3'd5) ? 3'd0 : phase_ff + 3'd1;
                  end
               end else if (el >= les_pkg::SHOW_MS) begin
                  // show over: put the saved colour back once
                  if (saved_flag_ff) begin
                     result.led_write  = 1'b1;
                     result.red        = saved_ff.red;
                     result.green      = saved_ff.green;
                     result.blue       = saved_ff.blue;
                     result.brightness = saved_ff.brightness;
                     saved_flag_in     = 1'b0;
                  end
               end else begin
                  result.keep_going = 1'b1;
                  if (due) begin
                     deadline_in       = item.now_ms + {16'd0, cfg.update_step_ms};
                     result.led_write  = 1'b1;
                     result.red        = frame.red;
                     result.green      = frame.green;
                     result.blue       = frame.blue;
                     result.brightness = frame.brightness;
                  end
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_time_ff <= '0;
         deadline_ff   <= '0;
         phase_ff      <= '0;
         led_ready_ff  <= 1'b0;
         saved_flag_ff <= 1'b0;
         saved_ff      <= '0;
      end else if (fire) begin
         start_time_ff <= start_time_in;
         deadline_ff   <= deadline_in;
         phase_ff      <= phase_in;
         led_ready_ff  <= led_ready_in;
         saved_flag_ff <= saved_flag_in;
         saved_ff      <= saved_in;
      end
   end

endmodule

// ===== rtl/les_checker.sv =====
// port-level checks of the led effect sequencer, bound to the top level
module les_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input les_pkg::rsp_type rsp_data
);

   // a stalled result holds until its transfer
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // no write means blank colour fields
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.led_write |->
         rsp_data.red == 8'd0 && rsp_data.green == 8'd0 &&
         rsp_data.blue == 8'd0 && rsp_data.brightness == 8'd0)
      else $error("colour fields set without led write");

   // nothing comes out right after reset
   assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_valid && !req_stall)
      else $error("result or stall present after reset");

   // an empty output side never holds off the input
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled while result side free");

endmodule

bind led_effect_sequencer les_checker u_les_checker (.*);
